// ----- rtl/twtlc_pkg.sv -----
// Package for the two-way traffic light controller.
// Holds the register indexes, reset values, the lamp bundle type and a small helper.
// It has no dependencies.
package twtlc_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_GREEN_TIME  = 2'd0;
    localparam logic [1:0] CFG_YELLOW_TIME = 2'd1;
    localparam logic [1:0] CFG_HOLD_TIME   = 2'd2;

    // Reset values of the timing registers.
    localparam logic [7:0] GREEN_TIME_RST  = 8'd10;
    localparam logic [7:0] YELLOW_TIME_RST = 8'd5;
    localparam logic [7:0] HOLD_TIME_RST   = 8'd5;

    // The phase timer saturates at this value.
    localparam logic [8:0] ELAPSED_MAX = 9'd511;

    // Lamp states and turn owner for one tick.
    typedef struct packed {
        logic green_a;
        logic yellow_a;
        logic red_a;
        logic green_b;
        logic yellow_b;
        logic red_b;
        logic active_side;
    } t_lamps;

    // A time register of zero behaves as one.
    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

// ----- rtl/two_way_traffic_light_controller_top.sv -----
// A result is valid in the cycle after its tick request is accepted. Throughput:
// one tick per clock unless stalled; the whole tick update is one register stage,
// and the output register lets a new tick enter while the last result is taken.
// Reset (synchronous, active low) gives approach A the turn in green, clears the
// phase timer and button state, and loads green 10, yellow 5 and hold 5 ticks.
// Depends on twtlc_pkg.
module two_way_traffic_light_controller_top #(
    parameter int TIMER_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Tick request channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_button_a,
    input  logic       i_button_b,
    // Result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_green_a,
    output logic       o_yellow_a,
    output logic       o_red_a,
    output logic       o_green_b,
    output logic       o_yellow_b,
    output logic       o_red_b,
    output logic       o_active_side,
    // Configuration write port
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wr_data
);

    localparam int CMP_W = (TIMER_BITS > 8) ? TIMER_BITS : 8;
    localparam logic [TIMER_BITS-1:0] HOLD_MAX = {TIMER_BITS{1'b1}};

    // Configuration registers
    logic [7:0] r_green_time;
    logic [7:0] r_yellow_time;
    logic [7:0] r_hold_time;

    // Controller state
    logic                  r_turn_owner, n_turn_owner;
    logic                  r_in_yellow, n_in_yellow;
    logic [8:0]            r_elapsed, n_elapsed;
    logic [1:0]            r_press_seen, n_press_seen;
    logic [TIMER_BITS-1:0] r_hold_count [2];
    logic [TIMER_BITS-1:0] n_hold_count [2];
    logic [1:0]            r_req_sent, n_req_sent;

    // Output register
    logic                  r_out_valid;
    twtlc_pkg::t_lamps     r_lamps, n_lamps;

    logic                  w_in_accept;
    logic [1:0]            w_level;
    logic [1:0]            w_fire;
    logic [CMP_W-1:0]      w_hold_lim;
    logic [7:0]            w_green;
    logic [7:0]            w_yellow;
    logic                  w_yel_mid;
    logic [8:0]            w_elapsed_mid;
    logic [8:0]            w_elapsed_inc;
    logic [9:0]            w_end_limit;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_level     = {i_button_b, i_button_a};
    assign w_green     = twtlc_pkg::at_least_one(r_green_time);
    assign w_yellow    = twtlc_pkg::at_least_one(r_yellow_time);
    assign w_hold_lim  = CMP_W'(twtlc_pkg::at_least_one(r_hold_time));
    assign w_end_limit = 10'(w_green) + 10'(w_yellow);

    // Button handling: per approach press tracking and request detection.
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n_press_seen[i] = r_press_seen[i];
            n_hold_count[i] = r_hold_count[i];
            n_req_sent[i]   = r_req_sent[i];
            w_fire[i]       = 1'b0;
            if (!w_level[i]) begin
                n_press_seen[i] = 1'b0;
                n_hold_count[i] = '0;
                n_req_sent[i]   = 1'b0;
            end else begin
                if (!r_press_seen[i]) begin
                    n_press_seen[i] = 1'b1;
                    n_hold_count[i] = '0;
                end else if (r_hold_count[i] != HOLD_MAX) begin
                    n_hold_count[i] = r_hold_count[i] + 1'b1;
                end
                if ((CMP_W'(n_hold_count[i]) >= w_hold_lim) && !r_req_sent[i]
                        && (r_turn_owner != 1'(i))) begin
                    w_fire[i]     = 1'b1;
                    n_req_sent[i] = 1'b1;
                end
            end
        end
    end

    // A request cuts a running green short; only the waiting side can fire.
    always_comb begin
        w_yel_mid     = r_in_yellow;
        w_elapsed_mid = r_elapsed;
        if ((w_fire != 2'b00) && !r_in_yellow) begin
            w_yel_mid     = 1'b1;
            w_elapsed_mid = 9'(w_green);
        end
    end

    // Lamps for this tick come from the state after the buttons.
    always_comb begin
        n_lamps.green_a     = !r_turn_owner && !w_yel_mid;
        n_lamps.yellow_a    = !r_turn_owner && w_yel_mid;
        n_lamps.red_a       = r_turn_owner;
        n_lamps.green_b     = r_turn_owner && !w_yel_mid;
        n_lamps.yellow_b    = r_turn_owner && w_yel_mid;
        n_lamps.red_b       = !r_turn_owner;
        n_lamps.active_side = r_turn_owner;
    end

    // Phase timer advance and turn change.
    always_comb begin
        w_elapsed_inc = (w_elapsed_mid < twtlc_pkg::ELAPSED_MAX) ?
                        w_elapsed_mid + 9'd1 : w_elapsed_mid;
        n_in_yellow   = w_yel_mid;
        n_elapsed     = w_elapsed_inc;
        n_turn_owner  = r_turn_owner;
        if (!w_yel_mid && (w_elapsed_inc >= 9'(w_green))) begin
            n_in_yellow = 1'b1;
        end
        if (n_in_yellow && (10'(w_elapsed_inc) >= w_end_limit)) begin
            n_turn_owner = !r_turn_owner;
            n_in_yellow  = 1'b0;
            n_elapsed    = '0;
        end
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green_time  <= twtlc_pkg::GREEN_TIME_RST;
            r_yellow_time <= twtlc_pkg::YELLOW_TIME_RST;
            r_hold_time   <= twtlc_pkg::HOLD_TIME_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                twtlc_pkg::CFG_GREEN_TIME:  r_green_time  <= i_cfg_wr_data;
                twtlc_pkg::CFG_YELLOW_TIME: r_yellow_time <= i_cfg_wr_data;
                twtlc_pkg::CFG_HOLD_TIME:   r_hold_time   <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // State update on each accepted tick request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_owner <= 1'b0;
            r_in_yellow  <= 1'b0;
            r_elapsed    <= '0;
            r_press_seen <= '0;
            r_req_sent   <= '0;
            r_hold_count <= '{default: '0};
        end else if (w_in_accept) begin
            r_turn_owner <= n_turn_owner;
            r_in_yellow  <= n_in_yellow;
            r_elapsed    <= n_elapsed;
            r_press_seen <= n_press_seen;
            r_req_sent   <= n_req_sent;
            r_hold_count <= n_hold_count;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_lamps <= n_lamps;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_green_a     = r_lamps.green_a;
    assign o_yellow_a    = r_lamps.yellow_a;
    assign o_red_a       = r_lamps.red_a;
    assign o_green_b     = r_lamps.green_b;
    assign o_yellow_b    = r_lamps.yellow_b;
    assign o_red_b       = r_lamps.red_b;
    assign o_active_side = r_lamps.active_side;

    // Each approach shows exactly one lamp.
    a_one_lamp_each: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($onehot({o_green_a, o_yellow_a, o_red_a}) &&
                         $onehot({o_green_b, o_yellow_b, o_red_b})))
        else $error("approach lamps are not one-hot");

    // The approach holding the turn is never red.
    a_owner_not_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_red_a == o_active_side) && (o_red_b == !o_active_side))
        else $error("turn owner shows red");

    // A pending result is never overwritten by a new request.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_in_accept)
        else $error("result overwritten while stalled");

    // A sent request or a running hold count belongs to a press in progress.
    a_req_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_req_sent & ~r_press_seen) == 2'b00) &&
        ((r_hold_count[0] == '0) || r_press_seen[0]) &&
        ((r_hold_count[1] == '0) || r_press_seen[1]))
        else $error("button state without a press");

    // Both approaches can never request in the same tick.
    a_single_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |-> $onehot0(w_fire))
        else $error("both approaches requested at once");

endmodule

// ----- verif/two_way_traffic_light_controller_top_tb.sv -----
// Self-checking testbench for the two-way traffic light controller.
// Streams button ticks through the valid/ready channels, predicts the lamps and compares them.
// Depends on twtlc_pkg and two_way_traffic_light_controller_top.
module two_way_traffic_light_controller_top_tb;

    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [1:0] CFG_SPARE = 2'd3;
    // Hold counter saturation value for the default 8-bit timer.
    localparam logic [7:0] HOLD_SAT = 8'hFF;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic button_a;
        logic button_b;
    } t_tick;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic       i_button_a = 1'b0;
    logic       i_button_b = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_green_a;
    logic       o_yellow_a;
    logic       o_red_a;
    logic       o_green_b;
    logic       o_yellow_b;
    logic       o_red_b;
    logic       o_active_side;
    logic       i_cfg_wr_en = 1'b0;
    logic [1:0] i_cfg_addr = 2'd0;
    logic [7:0] i_cfg_wr_data = 8'd0;

    // Stimulus and expected lamp queues.
    t_tick             tick_queue[$];
    twtlc_pkg::t_lamps lamps_due[$];

    // Shadow of the timing registers.
    logic [7:0] cfg_green = twtlc_pkg::GREEN_TIME_RST;
    logic [7:0] cfg_yellow = twtlc_pkg::YELLOW_TIME_RST;
    logic [7:0] cfg_hold = twtlc_pkg::HOLD_TIME_RST;

    // Shadow of the controller state; index 0 is approach A, 1 is approach B.
    bit          owner_b = 1'b0;
    bit          yellow_phase = 1'b0;
    int unsigned elapsed_ticks = 0;
    bit          pressed [2] = '{1'b0, 1'b0};
    logic [7:0]  held_ticks [2] = '{8'd0, 8'd0};
    bit          request_done [2] = '{1'b0, 1'b0};

    int                err_count = 0;
    int                n_queued = 0;
    int                n_accepted = 0;
    int                cycle_count = 0;
    bit                tick_taken = 1'b0;
    int                src_gap = 0;
    int                sink_gap = 0;
    int                sink_block_left = 0;
    bit                src_idle_en = 1'b1;
    bit                sink_idle_en = 1'b1;
    t_tick             next_tick;
    twtlc_pkg::t_lamps seen_lamps;
    twtlc_pkg::t_lamps want_lamps;
    string  lamp_name [0:6] = '{"active_side", "red_b", "yellow_b", "green_b",
                                "red_a", "yellow_a", "green_a"};

    two_way_traffic_light_controller_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_button_a    (i_button_a),
        .i_button_b    (i_button_b),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_green_a     (o_green_a),
        .o_yellow_a    (o_yellow_a),
        .o_red_a       (o_red_a),
        .o_green_b     (o_green_b),
        .o_yellow_b    (o_yellow_b),
        .o_red_b       (o_red_b),
        .o_active_side (o_active_side),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A programmed time of zero behaves as one tick.
    function automatic int unsigned eff_time(input logic [7:0] v);
        return (v == 8'd0) ? 1 : int'(v);
    endfunction

    // Advances the shadow controller by one tick and returns the lamps lit during it.
    function automatic twtlc_pkg::t_lamps traffic_step(input logic btn_a, input logic btn_b);
        logic [1:0]        level;
        int unsigned       green_lim;
        int unsigned       yellow_lim;
        twtlc_pkg::t_lamps lamps;
        level = {btn_b, btn_a};
        green_lim = eff_time(cfg_green);
        yellow_lim = eff_time(cfg_yellow);

        // Buttons first: track each press and raise at most one request per press.
        for (int s = 0; s < 2; s++) begin
            if (!level[s]) begin
                pressed[s] = 1'b0;
                held_ticks[s] = 8'd0;
                request_done[s] = 1'b0;
            end else begin
                if (!pressed[s]) begin
                    pressed[s] = 1'b1;
                    held_ticks[s] = 8'd0;
                end else if (held_ticks[s] != HOLD_SAT) begin
                    held_ticks[s] = held_ticks[s] + 8'd1;
                end
                if (held_ticks[s] >= eff_time(cfg_hold) && !request_done[s] &&
                    int'(owner_b) != s) begin
                    if (!yellow_phase) begin
                        elapsed_ticks = green_lim;
                        yellow_phase = 1'b1;
                    end
                    request_done[s] = 1'b1;
                end
            end
        end

        // Lamps come from the state after the buttons were handled.
        lamps.green_a = !owner_b && !yellow_phase;
        lamps.yellow_a = !owner_b && yellow_phase;
        lamps.red_a = owner_b;
        lamps.green_b = owner_b && !yellow_phase;
        lamps.yellow_b = owner_b && yellow_phase;
        lamps.red_b = !owner_b;
        lamps.active_side = owner_b;

        // Phase timer: green, then yellow, then the turn passes.
        if (elapsed_ticks < int'(twtlc_pkg::ELAPSED_MAX)) begin
            elapsed_ticks++;
        end
        if (!yellow_phase && elapsed_ticks >= green_lim) begin
            yellow_phase = 1'b1;
        end
        if (yellow_phase && elapsed_ticks >= green_lim + yellow_lim) begin
            owner_b = !owner_b;
            yellow_phase = 1'b0;
            elapsed_ticks = 0;
        end
        return lamps;
    endfunction

    // Monitor: check results, predict accepted ticks, and track register writes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                seen_lamps = {o_green_a, o_yellow_a, o_red_a, o_green_b, o_yellow_b,
                              o_red_b, o_active_side};
                if (lamps_due.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, actual %b",
                             $time, seen_lamps);
                end else begin
                    want_lamps = lamps_due.pop_front();
                    for (int k = 0; k < 7; k++) begin
                        if (seen_lamps[k] !== want_lamps[k]) begin
                            err_count++;
                            $display("%0t: %s mismatch, expected %b, actual %b",
                                     $time, lamp_name[k], want_lamps[k], seen_lamps[k]);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                lamps_due.push_back(traffic_step(i_button_a, i_button_b));
                n_accepted++;
                tick_taken = 1'b1;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    twtlc_pkg::CFG_GREEN_TIME:  cfg_green = i_cfg_wr_data;
                    twtlc_pkg::CFG_YELLOW_TIME: cfg_yellow = i_cfg_wr_data;
                    twtlc_pkg::CFG_HOLD_TIME:   cfg_hold = i_cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // Driver: offers queued ticks, holding each request until it is taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || tick_taken) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_in_valid <= 1'b0;
                end else if (tick_queue.size() > 0) begin
                    next_tick = tick_queue.pop_front();
                    i_button_a <= next_tick.button_a;
                    i_button_b <= next_tick.button_b;
                    i_in_valid <= 1'b1;
                    if (src_idle_en && $urandom_range(0, 4) == 0) begin
                        src_gap = $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            tick_taken = 1'b0;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off counted down here.
    always @(negedge i_clk) begin
        if (sink_block_left > 0) begin
            sink_block_left--;
            i_out_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            i_out_ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
            sink_gap = $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_tick(input logic btn_a, input logic btn_b);
        tick_queue.push_back('{button_a: btn_a, button_b: btn_b});
        n_queued++;
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wr_data <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Returns once every queued tick has been taken and its result checked.
    task automatic wait_drained();
        @(negedge i_clk);
        while (n_accepted != n_queued || lamps_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Button traffic: overlapping presses of random length around the hold time,
    // an occasional very long press, and some random noise ticks.
    task automatic gen_ticks(input int count, input int hold);
        int         press_left [2];
        int         rest_left [2];
        logic [1:0] level;
        press_left = '{0, 0};
        rest_left = '{0, 0};
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                level = 2'($urandom_range(0, 3));
            end else begin
                for (int s = 0; s < 2; s++) begin
                    if (press_left[s] == 0 && rest_left[s] == 0) begin
                        if ($urandom_range(0, 7) == 0) begin
                            press_left[s] = $urandom_range(256, 600);
                        end else begin
                            press_left[s] = $urandom_range(1, hold + 4);
                        end
                        rest_left[s] = $urandom_range(1, 6);
                    end
                    if (press_left[s] > 0) begin
                        level[s] = 1'b1;
                        press_left[s]--;
                    end else begin
                        level[s] = 1'b0;
                        rest_left[s]--;
                    end
                end
            end
            add_tick(level[0], level[1]);
        end
    endtask

    // One setting of the timing registers followed by random traffic.
    task automatic run_phase(input logic [7:0] g, input logic [7:0] y, input logic [7:0] h,
                             input int count);
        wait_drained();
        write_reg(twtlc_pkg::CFG_GREEN_TIME, g);
        write_reg(twtlc_pkg::CFG_YELLOW_TIME, y);
        write_reg(twtlc_pkg::CFG_HOLD_TIME, h);
        gen_ticks(count, eff_time(h));
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero times act as one tick; the spare index must not disturb anything.
        write_reg(twtlc_pkg::CFG_GREEN_TIME, 8'd0);
        write_reg(twtlc_pkg::CFG_YELLOW_TIME, 8'd0);
        write_reg(twtlc_pkg::CFG_HOLD_TIME, 8'd0);
        write_reg(CFG_SPARE, 8'hA5);
        add_tick(1'b0, 1'b0);
        add_tick(1'b1, 1'b1);
        add_tick(1'b1, 1'b0);
        add_tick(1'b0, 1'b1);
        add_tick(1'b1, 1'b1);
        add_tick(1'b0, 1'b0);
        add_tick(1'b0, 1'b1);
        add_tick(1'b0, 1'b1);
        add_tick(1'b1, 1'b0);
        add_tick(1'b1, 1'b0);
        wait_drained();

        // Default times: B held long enough cuts A's green, then A, pressed as its own
        // yellow ends and held long enough into B's turn, cuts B's green.
        write_reg(twtlc_pkg::CFG_GREEN_TIME, twtlc_pkg::GREEN_TIME_RST);
        write_reg(twtlc_pkg::CFG_YELLOW_TIME, twtlc_pkg::YELLOW_TIME_RST);
        write_reg(twtlc_pkg::CFG_HOLD_TIME, twtlc_pkg::HOLD_TIME_RST);
        repeat (8) add_tick(1'b0, 1'b1);
        add_tick(1'b0, 1'b0);
        repeat (4) add_tick(1'b1, 1'b0);
        repeat (3) add_tick(1'b1, 1'b1);

        run_phase(8'd20, 8'd4, 8'd3, 250);
        run_phase(8'd255, 8'd255, 8'd255, 300);
        // Shrinking the times mid-turn ends an already passed phase at once.
        run_phase(8'd3, 8'd200, 8'd2, 200);
        run_phase(8'd1, 8'd1, 8'd1, 200);

        // Long receiver hold-off with the sender offering every cycle.
        wait_drained();
        src_idle_en = 1'b0;
        run_phase(8'($urandom_range(1, 40)), 8'($urandom_range(1, 10)),
                  8'($urandom_range(1, 12)), 250);
        @(posedge i_clk);
        sink_block_left = 120;
        wait_drained();
        src_idle_en = 1'b1;

        run_phase(8'd0, 8'd0, 8'd0, 150);
        run_phase(8'd8, 8'd3, 8'd255, 200);

        // Final stretch without any idling.
        wait_drained();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        run_phase(8'($urandom_range(0, 30)), 8'($urandom_range(0, 8)),
                  8'($urandom_range(0, 10)), 250);

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (err_count == 0 && lamps_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
